@@ rtl/u8cpt_pkg.sv @@
// Shared types and constants for the UTF-8 code point counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package u8cpt_pkg;

    // Most result bytes one input byte can release (three flushed bytes plus the breaker)
    localparam int unsigned GROUP_MAX  = 4;
    localparam int unsigned GROUP_W    = 3;
    localparam int unsigned QDEPTH     = 8;
    localparam int unsigned QADDR_W    = 3;
    localparam int unsigned QCOUNT_W   = 4;
    localparam logic [16:0] COUNT_CAP  = 17'h10000;

    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] CODE_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;

    // One resolved byte waiting for its code point index
    typedef struct packed {
        logic [7:0] data;
        logic       new_point;   // byte opens a new code point
        logic       malformed;
        logic       final_byte;
    } op_t;

    // Group of resolved bytes written into the queue in one cycle
    typedef struct packed {
        logic [GROUP_W-1:0]      count;
        op_t [GROUP_MAX-1:0]     ops;
    } push_t;

endpackage

@@ rtl/u8cpt_front.sv @@
// Front end: accepts text bytes, tracks the pending UTF-8 sequence and
// resolves bytes into groups for the queue. Depends on u8cpt_pkg.
`timescale 1ns / 1ps

module u8cpt_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_text_byte,
    input  logic            s_end_of_text,
    input  logic            q_room,
    output u8cpt_pkg::push_t push
);
    import u8cpt_pkg::*;

    logic [7:0] pend_reg [3];
    logic [7:0] pend_next [3];
    logic [1:0] plen_reg, plen_next;
    logic [1:0] need_reg, need_next;

    logic       accept;
    logic       is_cont, is_ascii, has_pend, cont_path, comp, emit_pend;
    logic       b_emit, b_mal, b_newp;
    logic [1:0] need_b, pend_n;
    logic [2:0] n, n_last;

    function automatic logic [1:0] lead_need(input logic [7:0] b);
        if ((b & MASK_LEAD2) == MASK_CONT)
            return 2'd1;
        else if ((b & MASK_LEAD3) == MASK_LEAD2)
            return 2'd2;
        else if ((b & MASK_LEAD4) == MASK_LEAD3)
            return 2'd3;
        else
            return 2'd0;
    endfunction

    assign s_ready = q_room;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_cont   = (s_text_byte & MASK_CONT) == CODE_CONT;
        is_ascii  = !s_text_byte[7];
        need_b    = lead_need(s_text_byte);
        has_pend  = plen_reg != 2'd0;
        cont_path = has_pend && is_cont;
        // continuation that finishes the sequence (plen counts the lead too)
        comp      = cont_path && (plen_reg >= need_reg);
        emit_pend = has_pend && (!is_cont || comp || s_end_of_text);

        if (cont_path) begin
            b_emit = comp || s_end_of_text;
            b_mal  = !comp;
            b_newp = !comp;
        end else begin
            b_emit = is_ascii || (need_b == 2'd0) || s_end_of_text;
            b_mal  = !is_ascii;
            b_newp = 1'b1;
        end

        pend_n = emit_pend ? plen_reg : 2'd0;
        n      = {1'b0, pend_n} + {2'b00, b_emit};
        n_last = n - 3'd1;

        push.ops = '0;
        for (int j = 0; j < 3; j++) begin
            push.ops[j].data      = pend_reg[j];
            push.ops[j].new_point = !comp || (j == 0);
            push.ops[j].malformed = !comp;
        end
        push.ops[pend_n].data      = s_text_byte;
        push.ops[pend_n].new_point = b_newp;
        push.ops[pend_n].malformed = b_mal;
        push.ops[pend_n].final_byte = 1'b0;
        if (s_end_of_text && (n != 3'd0))
            push.ops[n_last[1:0]].final_byte = 1'b1;
        push.count = accept ? n : 3'd0;

        // next sequence state
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pend_next[2] = pend_reg[2];
        plen_next    = 2'd0;
        need_next    = 2'd0;
        if (s_end_of_text) begin
            pend_next[0] = 8'd0;
            pend_next[1] = 8'd0;
            pend_next[2] = 8'd0;
        end else if (cont_path && !comp) begin
            case (plen_reg)
                2'd1:    pend_next[1] = s_text_byte;
                default: pend_next[2] = s_text_byte;
            endcase
            plen_next = plen_reg + 2'd1;
            need_next = need_reg;
        end else if (!cont_path && !is_ascii && (need_b != 2'd0)) begin
            pend_next[0] = s_text_byte;
            plen_next    = 2'd1;
            need_next    = need_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= 2'd0;
            need_reg <= 2'd0;
        end else if (accept) begin
            plen_reg <= plen_next;
            need_reg <= need_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pend_reg[0] <= pend_next[0];
            pend_reg[1] <= pend_next[1];
            pend_reg[2] <= pend_next[2];
        end
    end

endmodule

@@ rtl/u8cpt_queue.sv @@
// Short queue between front and back end: takes up to four resolved bytes
// per cycle, hands out one per cycle while the back end pops. Depends on u8cpt_pkg.
`timescale 1ns / 1ps

module u8cpt_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  u8cpt_pkg::push_t    push,
    output logic                room,
    output logic                head_valid,
    output u8cpt_pkg::op_t      head,
    input  logic                pop
);
    import u8cpt_pkg::*;

    op_t                 mem_reg [QDEPTH];
    logic [QADDR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QADDR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;
    logic                do_pop;

    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];
    // a whole group must fit before the next byte is taken
    assign room       = count_reg <= QCOUNT_W'(QDEPTH - GROUP_MAX);
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + QADDR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QADDR_W'(do_pop);
        count_next  = count_reg + QCOUNT_W'(push.count) - QCOUNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < GROUP_MAX; k++) begin
            if (GROUP_W'(k) < push.count)
                mem_reg[wr_ptr_reg + QADDR_W'(k)] <= push.ops[k];
        end
    end

endmodule

@@ rtl/u8cpt_back.sv @@
// Back end: assigns code point indexes, applies the limit and drives the
// result output register. Depends on u8cpt_pkg.
`timescale 1ns / 1ps

module u8cpt_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [15:0]     point_limit,
    input  logic            head_valid,
    input  u8cpt_pkg::op_t  head,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_kept,
    output logic            m_malformed,
    output logic            m_final_byte,
    output logic [16:0]     m_total_points,
    output logic            m_over_limit
);
    import u8cpt_pkg::*;

    logic [16:0] cnt_reg, cnt_next, cnt_inc;
    logic        last_kept_reg;
    logic        kept, over;
    logic [16:0] total, limit;

    logic        m_valid_reg;
    logic [7:0]  m_out_byte_reg;
    logic        m_kept_reg, m_malformed_reg, m_final_byte_reg, m_over_limit_reg;
    logic [16:0] m_total_points_reg;

    assign pop   = head_valid && (!m_valid_reg || m_ready);
    assign limit = {1'b0, point_limit};

    always_comb begin
        cnt_inc = (cnt_reg == COUNT_CAP) ? cnt_reg : cnt_reg + 17'd1;
        if (head.new_point) begin
            kept  = cnt_reg < limit;
            total = cnt_inc;
        end else begin
            // later bytes of a complete sequence share the lead's index
            kept  = last_kept_reg;
            total = cnt_reg;
        end
        over     = head.final_byte && (total > limit);
        cnt_next = head.final_byte ? 17'd0 : total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= 17'd0;
            last_kept_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                cnt_reg       <= cnt_next;
                last_kept_reg <= kept;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_out_byte_reg     <= head.data;
            m_kept_reg         <= kept;
            m_malformed_reg    <= head.malformed;
            m_final_byte_reg   <= head.final_byte;
            m_total_points_reg <= total;
            m_over_limit_reg   <= over;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_out_byte_reg;
    assign m_kept         = m_kept_reg;
    assign m_malformed    = m_malformed_reg;
    assign m_final_byte   = m_final_byte_reg;
    assign m_total_points = m_total_points_reg;
    assign m_over_limit   = m_over_limit_reg;

endmodule

@@ rtl/utf8_code_point_count_truncate_top.sv @@
// UTF-8 code point counter with truncation marks: one byte per clock in
// while s_ready is high, one resolved byte per clock out while m_ready is
// high, once each, in input order. A byte is released when its sequence
// completes or breaks, so a breaking byte can release up to four results at
// once; these go into an eight-entry queue and leave one per cycle, unless
// m_ready stalls, through the queue and then the output register. s_ready is
// low while the queue has fewer than four free entries. The user must write
// the limit register with cfg_we/cfg_wdata only between texts; the block does
// not enforce it. Depends on u8cpt_pkg and its submodules.
`timescale 1ns / 1ps

module utf8_code_point_count_truncate_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_kept,
    output logic        m_malformed,
    output logic        m_final_byte,
    output logic [16:0] m_total_points,
    output logic        m_over_limit,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import u8cpt_pkg::*;

    logic [15:0] point_limit_reg;
    push_t       push;
    logic        q_room, head_valid, pop;
    op_t         head;

    always_ff @(posedge aclk) begin
        if (!aresetn)
            point_limit_reg <= 16'hFFFF;
        else if (cfg_we)
            point_limit_reg <= cfg_wdata;
    end

    u8cpt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_end_of_text (s_end_of_text),
        .q_room        (q_room),
        .push          (push)
    );

    u8cpt_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .room       (q_room),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    u8cpt_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .point_limit     (point_limit_reg),
        .head_valid      (head_valid),
        .head            (head),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_kept          (m_kept),
        .m_malformed     (m_malformed),
        .m_final_byte    (m_final_byte),
        .m_total_points  (m_total_points),
        .m_over_limit    (m_over_limit)
    );

endmodule
